>>> rtl/bvr_pkg.sv
// ----------------------------------------------------------------------------
// bvr_pkg: shared definitions for the Berendsen velocity rescaling block
// Widths, register indexes, reset values and the interface type between the
// sequencer and the iterative divide / square root unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bvr_pkg;

  // Field widths.
  localparam int TEMP_W     = 24;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int VEL_W      = 32;
  localparam int FACTOR_W   = 32;
  localparam int S_TDATA_W  = 120;
  localparam int M_TDATA_W  = 128;

  // Shared multiplier: 33 x 33 signed, so both unsigned 32-bit and signed
  // 32-bit operands fit.
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;

  // Factor arithmetic widths.
  localparam int DEN_W      = 56;            // tau * T
  localparam int SUM_W      = DEN_W + 1;     // tau * T + dt * T0
  localparam int QUO_W      = 64;            // p * 2^60 / den
  localparam int DVS_W      = DEN_W + 3;     // divisor scaled by eight
  localparam int DREM_W     = DVS_W + 1;     // partial remainder
  localparam int SREM_W     = FACTOR_W + 2;  // square root remainder
  localparam int SUB_W      = DREM_W + 1;    // shared subtractor width
  localparam int CNT_W      = $clog2(QUO_W);

  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(FACTOR_W - 1);

  // Velocity scaling.
  localparam int FRAC_SHIFT = 30;
  localparam int SAT_LO     = FRAC_SHIFT + VEL_W - 1;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SHIFT - 1);
  localparam logic [VEL_W-1:0]  VEL_MAX    = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0]  VEL_MIN    = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic [1:0]        VMUL_LAST  = 2'd3;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_SHIFT;
  localparam logic [FACTOR_W-1:0] FACTOR_SAT = '1;

  // Register map.
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_TARGET_TEMP   = 2'd0;
  localparam cfg_index_t REG_TIME_STEP     = 2'd1;
  localparam cfg_index_t REG_COUPLING_TIME = 2'd2;

  localparam logic [TEMP_W-1:0] TARGET_TEMP_RESET   = 24'd76800;
  localparam logic [CFG_W-1:0]  TIME_STEP_RESET     = 32'd1;
  localparam logic [CFG_W-1:0]  COUPLING_TIME_RESET = 32'd100;

  // Item kinds carried on tuser.
  localparam logic MODE_START    = 1'b0;
  localparam logic MODE_VELOCITY = 1'b1;

  // Result of the divide / square root unit.
  typedef struct packed {
    logic                done;
    logic [FACTOR_W-1:0] root;
  } ds_result_t;

endpackage

>>> rtl/bvr_mul.sv
// ----------------------------------------------------------------------------
// bvr_mul: shared registered multiplier
// One 33 x 33 signed multiply per cycle with the product registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvr_mul import bvr_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

>>> rtl/bvr_divsqrt.sv
// ----------------------------------------------------------------------------
// bvr_divsqrt: iterative fractional divide followed by integer square root
// Computes floor(sqrt(floor(p * 2^60 / den))) one bit per cycle, with a
// single subtractor shared between the divide and the root phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvr_divsqrt import bvr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output ds_result_t       result
);

  typedef enum logic [1:0] {PH_IDLE, PH_DIV, PH_SQRT} phase_t;

  phase_t              phase;
  logic [CNT_W-1:0]    cnt;
  logic [DREM_W-1:0]   drem;
  logic [DVS_W-1:0]    dvs;
  logic [QUO_W-1:0]    quo;
  logic [SREM_W-1:0]   srem;
  logic [FACTOR_W-1:0] root_q;
  logic                done;

  logic [SREM_W+1:0]   sq_minu;
  logic [SUB_W-1:0]    minu;
  logic [SUB_W-1:0]    subt;
  logic [SUB_W:0]      diff;
  logic                ge;

  // The divisor is pre-scaled by eight so the first step yields quotient
  // bit 63; the root consumes the quotient two bits at a time from the top.
  always_comb begin
    sq_minu = {srem, quo[QUO_W-1 -: 2]};
    if (phase == PH_SQRT) begin
      minu = SUB_W'(sq_minu);
      subt = SUB_W'({root_q, 2'b01});
    end else begin
      minu = SUB_W'(drem);
      subt = SUB_W'(dvs);
    end
    diff = {1'b0, minu} - {1'b0, subt};
    ge   = ~diff[SUB_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_DIV;
            cnt   <= '0;
            drem  <= DREM_W'(dividend);
            dvs   <= {divisor, 3'b000};
            quo   <= '0;
          end
        end
        PH_DIV: begin
          if (ge) begin
            drem <= {diff[DREM_W-2:0], 1'b0};
            quo  <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            drem <= {drem[DREM_W-2:0], 1'b0};
            quo  <= {quo[QUO_W-2:0], 1'b0};
          end
          if (cnt == DIV_LAST) begin
            phase  <= PH_SQRT;
            cnt    <= '0;
            srem   <= '0;
            root_q <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        PH_SQRT: begin
          quo <= {quo[QUO_W-3:0], 2'b00};
          if (ge) begin
            srem   <= diff[SREM_W-1:0];
            root_q <= {root_q[FACTOR_W-2:0], 1'b1};
          end else begin
            srem   <= sq_minu[SREM_W-1:0];
            root_q <= {root_q[FACTOR_W-2:0], 1'b0};
          end
          if (cnt == SQRT_LAST) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign result.done = done;
  assign result.root = root_q;

endmodule

>>> rtl/berendsen_velocity_rescale.sv
// ----------------------------------------------------------------------------
// berendsen_velocity_rescale: Berendsen thermostat velocity rescaling
// A start beat (tuser = 0) carries the current temperature; the block then
// computes lambda = sqrt(1 + (dt/tau)(T0/T - 1)) as an unsigned Q2.30 factor
// and keeps it. Velocity beats (tuser = 1) carry three Q16.16 components and
// are returned multiplied by the kept factor, rounded and saturated.
// Every input beat produces exactly one output beat: zero velocities plus the
// new factor and skip flag for a start beat, the scaled components plus the
// factor and flag in use for a velocity beat.
// One item is worked on at a time and s_axis_tready is high only while the
// sequencer is idle. A velocity beat passes its three components through the
// one shared multiplier, then a flush step, then the output load. A start
// beat runs three multiplies and, unless the factor saturates or the step is
// skipped, a 64-step restoring divide and a 32-step square root through one
// subtractor. A zero temperature or coupling time skips all arithmetic. A
// stalled receiver only holds the block back once a second result waits
// behind the output register. Reset (rst, synchronous) loads the register
// defaults, sets the factor to one and the skip flag, and empties the
// output. Configuration writes must be idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module berendsen_velocity_rescale import bvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata, from bit 0: current_temperature[23:0], vel_x[55:24],
  // vel_y[87:56], vel_z[119:88]
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: mode
  input  logic                  s_axis_tuser,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata, from bit 0: scaled_x[31:0], scaled_y[63:32], scaled_z[95:64],
  // factor_out[127:96]
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: skipped
  output logic                  m_axis_tuser,
  // Configuration write port.
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_DEN,
    S_MUL_A,
    S_MUL_B,
    S_CMP,
    S_RANGE,
    S_ROOT,
    S_VMUL,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [TEMP_W-1:0]   goal_temp;
  logic [CFG_W-1:0]    time_step;
  logic [CFG_W-1:0]    coupling_time;

  // Thermostat state.
  logic [FACTOR_W-1:0] scale_factor;
  logic                skip_flag;

  // Working registers.
  logic [TEMP_W-1:0]   cur_temp;
  logic [VEL_W-1:0]    vel_a;
  logic [VEL_W-1:0]    vel_b;
  logic [VEL_W-1:0]    vel_c;
  logic [VEL_W-1:0]    res_x;
  logic [VEL_W-1:0]    res_y;
  logic [VEL_W-1:0]    res_z;
  logic [1:0]          cnt_v;
  logic [DEN_W-1:0]    den;
  logic [SUM_W-1:0]    asum;
  logic [SUM_W-1:0]    pdiff;

  // Input fields.
  logic [TEMP_W-1:0]   in_temp;
  logic [VEL_W-1:0]    in_vx;
  logic [VEL_W-1:0]    in_vy;
  logic [VEL_W-1:0]    in_vz;

  // Shared multiplier.
  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic [DEN_W-1:0]         prod_lo;

  // Rounding and saturation of a scaled component.
  logic [PROD_W-1:0]   rnd_sum;
  logic [VEL_W-1:0]    scaled;

  logic                zero_case;
  logic                range_sat;
  logic                ds_start;
  logic                out_load;
  ds_result_t          ds_res;

  assign in_temp = s_axis_tdata[TEMP_W-1:0];
  assign in_vx   = s_axis_tdata[TEMP_W +: VEL_W];
  assign in_vy   = s_axis_tdata[TEMP_W + VEL_W +: VEL_W];
  assign in_vz   = s_axis_tdata[TEMP_W + 2*VEL_W +: VEL_W];

  assign s_axis_tready = (state == S_IDLE);

  // The finished result moves into the output register once that register
  // is empty or being drained in the same cycle.
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // A zero temperature on either side, or a zero coupling time, disables
  // scaling for the step without any arithmetic.
  assign zero_case = (in_temp == '0) || (goal_temp == '0) ||
                     (coupling_time == '0);

  // Operand selection for the shared multiplier. All factor products are
  // unsigned and are zero-extended; velocities are sign-extended.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_MUL_DEN: begin
        op_a = MUL_W'(coupling_time);
        op_b = MUL_W'(cur_temp);
      end
      S_MUL_A: begin
        op_a = MUL_W'(time_step);
        op_b = MUL_W'(goal_temp);
      end
      S_MUL_B: begin
        op_a = MUL_W'(time_step);
        op_b = MUL_W'(cur_temp);
      end
      S_VMUL: begin
        op_a = {vel_a[VEL_W-1], vel_a};
        op_b = {1'b0, scale_factor};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  bvr_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign prod_lo = prod[DEN_W-1:0];

  // Round to nearest with ties upward, then drop 30 fraction bits. The result
  // fits 32 bits only when the bits above the new sign bit all match it.
  always_comb begin
    rnd_sum = prod + ROUND_HALF;
    if ((&rnd_sum[PROD_W-1:SAT_LO]) || !(|rnd_sum[PROD_W-1:SAT_LO])) begin
      scaled = rnd_sum[SAT_LO:FRAC_SHIFT];
    end else if (rnd_sum[PROD_W-1]) begin
      scaled = VEL_MIN;
    end else begin
      scaled = VEL_MAX;
    end
  end

  // lambda squared of sixteen or more saturates the factor.
  assign range_sat = ({3'b000, pdiff} >= {den, 4'b0000});
  assign ds_start  = (state == S_RANGE) && !range_sat;

  bvr_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ds_start),
    .dividend (pdiff),
    .divisor  (den),
    .result   (ds_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      goal_temp     <= TARGET_TEMP_RESET;
      time_step     <= TIME_STEP_RESET;
      coupling_time <= COUPLING_TIME_RESET;
      scale_factor  <= FACTOR_ONE;
      skip_flag     <= 1'b1;
      cnt_v         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_TEMP:   goal_temp     <= cfg_data[TEMP_W-1:0];
          REG_TIME_STEP:     time_step     <= cfg_data;
          REG_COUPLING_TIME: coupling_time <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == MODE_VELOCITY) begin
              vel_a <= in_vx;
              vel_b <= in_vy;
              vel_c <= in_vz;
              cnt_v <= '0;
              state <= S_VMUL;
            end else begin
              cur_temp <= in_temp;
              res_x    <= '0;
              res_y    <= '0;
              res_z    <= '0;
              if (zero_case) begin
                scale_factor <= FACTOR_ONE;
                skip_flag    <= 1'b1;
                state        <= S_OUT;
              end else begin
                state <= S_MUL_DEN;
              end
            end
          end
        end
        S_MUL_DEN: state <= S_MUL_A;
        S_MUL_A: begin
          // tau * T is ready.
          den   <= prod_lo;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          // dt * T0 is ready.
          asum  <= SUM_W'(den) + SUM_W'(prod_lo);
          state <= S_CMP;
        end
        S_CMP: begin
          // dt * T is ready; lambda squared is (asum - dt*T) / den.
          if (asum <= SUM_W'(prod_lo)) begin
            scale_factor <= FACTOR_ONE;
            skip_flag    <= 1'b1;
            state        <= S_OUT;
          end else begin
            pdiff <= asum - SUM_W'(prod_lo);
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (range_sat) begin
            scale_factor <= FACTOR_SAT;
            skip_flag    <= 1'b0;
            state        <= S_OUT;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (ds_res.done) begin
            scale_factor <= ds_res.root;
            skip_flag    <= 1'b0;
            state        <= S_OUT;
          end
        end
        S_VMUL: begin
          // Components enter the multiplier in x, y, z order and leave it
          // in the next cycle; both sides move through shift registers.
          vel_a <= vel_b;
          vel_b <= vel_c;
          if (cnt_v != '0) begin
            res_x <= res_y;
            res_y <= res_z;
            res_z <= scaled;
          end
          if (cnt_v == VMUL_LAST) begin
            state <= S_OUT;
          end else begin
            cnt_v <= cnt_v + 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_axis_tdata <= {scale_factor, res_z, res_y, res_x};
            m_axis_tuser <= skip_flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/rescale_checker.sv
// ----------------------------------------------------------------------------
// rescale_checker: result predictor and comparator for the velocity rescaler
// Watches the configuration port and both streams. Every accepted input beat
// is turned into a predicted result from a private copy of the registers and
// of the kept factor. Every accepted output beat is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rescale_checker import bvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  m_axis_tuser,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    results_due
);

  typedef struct packed {
    logic [VEL_W-1:0]    x;
    logic [VEL_W-1:0]    y;
    logic [VEL_W-1:0]    z;
    logic [FACTOR_W-1:0] factor;
    logic                skipped;
  } rescale_t;

  logic [TEMP_W-1:0]   target_k;
  logic [CFG_W-1:0]    dt_k;
  logic [CFG_W-1:0]    tau_k;
  logic [FACTOR_W-1:0] lambda_k;
  logic                bypass_k;
  rescale_t            due_rescales[$];
  int                  errs = 0;

  // lambda = sqrt((tau*T + dt*T0 - dt*T) / (tau*T)) in Q2.30, rounded down.
  function automatic logic [FACTOR_W-1:0] berendsen_lambda(
    input  logic [TEMP_W-1:0] t_now,
    input  logic [TEMP_W-1:0] t_goal,
    input  logic [CFG_W-1:0]  dt,
    input  logic [CFG_W-1:0]  tau,
    output logic              bypass
  );
    logic [63:0]         den;
    logic [63:0]         a;
    logic [63:0]         b;
    logic [63:0]         p;
    logic [127:0]        q;
    logic [63:0]         sq;
    logic [FACTOR_W-1:0] root;
    logic [FACTOR_W-1:0] trial;
    bypass = 1'b1;
    if (t_now == 0 || t_goal == 0 || tau == 0) return FACTOR_ONE;
    den = 64'(tau) * 64'(t_now);
    a = den + 64'(dt) * 64'(t_goal);
    b = 64'(dt) * 64'(t_now);
    if (a <= b) return FACTOR_ONE;
    bypass = 1'b0;
    p = a - b;
    if (p >= den * 64'd16) return FACTOR_SAT;
    q = {4'b0, p, 60'b0};
    q = q / {64'b0, den};
    // Bitwise square root of a value below 2^64.
    root = '0;
    for (int i = FACTOR_W - 1; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      sq = {32'b0, trial};
      sq = sq * sq;
      if (sq <= q[63:0]) root = trial;
    end
    return root;
  endfunction

  // Q16.16 times Q2.30, rounded half up, saturated to 32 bits.
  function automatic logic [VEL_W-1:0] rescale(input logic [VEL_W-1:0] v,
                                                input logic [FACTOR_W-1:0] f);
    logic signed [66:0] prod;
    prod = $signed({{35{v[31]}}, v}) * $signed({35'b0, f});
    prod = prod + 67'sd536870912;
    prod = prod >>> 30;
    if (prod > 67'sd2147483647) return VEL_MAX;
    if (prod < -67'sd2147483648) return VEL_MIN;
    return prod[31:0];
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    rescale_t got;
    rescale_t want;
    if (rst) begin
      target_k = TARGET_TEMP_RESET;
      dt_k     = TIME_STEP_RESET;
      tau_k    = COUPLING_TIME_RESET;
      lambda_k = FACTOR_ONE;
      bypass_k = 1'b1;
      due_rescales.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x       = m_axis_tdata[31:0];
        got.y       = m_axis_tdata[63:32];
        got.z       = m_axis_tdata[95:64];
        got.factor  = m_axis_tdata[127:96];
        got.skipped = m_axis_tuser;
        if (due_rescales.size() == 0) begin
          $error("result beat with no prediction waiting: 0x%h", m_axis_tdata);
          errs++;
        end else begin
          want = due_rescales.pop_front();
          check_field("scaled_x", want.x, got.x);
          check_field("scaled_y", want.y, got.y);
          check_field("scaled_z", want.z, got.z);
          check_field("factor_out", want.factor, got.factor);
          check_field("skipped", 32'(want.skipped), 32'(got.skipped));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_TEMP:   target_k = cfg_data[TEMP_W-1:0];
          REG_TIME_STEP:     dt_k = cfg_data;
          REG_COUPLING_TIME: tau_k = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == MODE_START) begin
          lambda_k = berendsen_lambda(s_axis_tdata[23:0], target_k, dt_k, tau_k,
                                      bypass_k);
          want.x = '0;
          want.y = '0;
          want.z = '0;
        end else begin
          want.x = rescale(s_axis_tdata[55:24], lambda_k);
          want.y = rescale(s_axis_tdata[87:56], lambda_k);
          want.z = rescale(s_axis_tdata[119:88], lambda_k);
        end
        want.factor  = lambda_k;
        want.skipped = bypass_k;
        due_rescales.push_back(want);
      end
    end
    results_due <= due_rescales.size();
    mismatches  <= errs;
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the Berendsen velocity rescaler
// Drives start beats and velocity beats through the input stream, writes the
// thermostat registers between phases and lets a separate checker predict and
// compare every result beat. A directed opening covers the zero temperature,
// zero coupling time, nonpositive and saturating lambda and rounding cases;
// random phases follow with random register settings and random idling on
// both streams, including a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bvr_pkg::*;

  // Longest stretch with no beat on either stream before the run is called
  // hung. This leaves a wide margin over the slowest start beat and the
  // longest receiver hold-off below.
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 110;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = MODE_START;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we = 1'b0;
  cfg_index_t           cfg_index = REG_TARGET_TEMP;
  logic [CFG_W-1:0]     cfg_data = '0;

  int                   mismatches;
  int                   results_due;
  int                   quiet_cycles = 0;

  // Shared pacing knobs: no_idle turns off random gaps on both streams, and
  // each bump of hold_asks makes the receiver hold off once, as set by LONG_HOLD.
  bit                   no_idle = 1'b0;
  int                   hold_asks = 0;

  // Target temperature last written, used to aim temperatures near it.
  logic [TEMP_W-1:0]    cur_t0 = TARGET_TEMP_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  berendsen_velocity_rescale u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rescale_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .results_due   (results_due)
  );

  // Gap length before a beat: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat and return at the edge where it is taken. The valid stays
  // high when the next beat follows without a gap, so it is never lowered
  // and raised in the same time step.
  task automatic offer(input logic mode, input logic [S_TDATA_W-1:0] payload);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= payload;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Start beats carry noise in the unused velocity bits, velocity beats
  // carry noise in the unused temperature bits.
  task automatic start_step(input logic [TEMP_W-1:0] temp);
    offer(MODE_START, {$urandom, $urandom, $urandom, temp});
  endtask

  task automatic velocity(input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
                          input logic [VEL_W-1:0] vz);
    offer(MODE_VELOCITY, {vz, vy, vx, TEMP_W'($urandom)});
  endtask

  // Stop offering and wait until every predicted result has been taken.
  // Each beat gives exactly one result, so the block is idle afterwards.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // Write all three registers on consecutive edges with the enable held high.
  task automatic load_config(input logic [TEMP_W-1:0] t0, input logic [CFG_W-1:0] dt,
                             input logic [CFG_W-1:0] tau);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TARGET_TEMP;
    cfg_data  <= CFG_W'(t0);
    @(posedge clk);
    cfg_index <= REG_TIME_STEP;
    cfg_data  <= dt;
    @(posedge clk);
    cfg_index <= REG_COUPLING_TIME;
    cfg_data  <= tau;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_t0 = t0;
  endtask

  // Random register setting for one phase. The shapes cover weak and strong
  // coupling, a dt/tau ratio of one, dt of zero and the register extremes.
  task automatic random_config();
    logic [TEMP_W-1:0] t0;
    logic [CFG_W-1:0]  dt;
    logic [CFG_W-1:0]  tau;
    case ($urandom_range(0, 5))
      0: begin
        t0  = TEMP_W'($urandom_range(2560, 128000));
        dt  = $urandom_range(1, 10);
        tau = $urandom_range(10, 2000);
      end
      1: begin
        t0  = TEMP_W'($urandom);
        dt  = $urandom;
        tau = $urandom;
      end
      2: begin
        t0  = TEMP_W'($urandom_range(2560, 128000));
        dt  = $urandom;
        tau = dt;
      end
      3: begin
        t0  = TEMP_W'($urandom);
        dt  = $urandom_range(100, 1000);
        tau = $urandom_range(1, 100);
      end
      4: begin
        t0  = $urandom_range(0, 1) ? '1 : TEMP_W'($urandom_range(0, 1));
        dt  = $urandom_range(0, 1) ? '1 : CFG_W'($urandom_range(0, 1));
        tau = $urandom_range(0, 1) ? '1 : CFG_W'(1);
      end
      default: begin
        t0  = TEMP_W'($urandom);
        dt  = '0;
        tau = $urandom;
      end
    endcase
    load_config(t0, dt, tau);
  endtask

  // Temperatures mostly lie near the target, so lambda stays in a useful
  // range; the rest are small, arbitrary or zero.
  function automatic logic [TEMP_W-1:0] pick_temperature();
    int base;
    int span;
    int tc;
    base = int'(cur_t0);
    span = base / 4 + 1;
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return TEMP_W'($urandom_range(1, 255));
      3, 4, 5: return TEMP_W'($urandom);
      default: begin
        tc = base - span + int'($urandom_range(0, 2 * span));
        if (tc < 0) tc = 0;
        if (tc > 16777215) tc = 16777215;
        return TEMP_W'(tc);
      end
    endcase
  endfunction

  function automatic logic [VEL_W-1:0] pick_velocity();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return VEL_MAX;
          1:       return VEL_MIN;
          2:       return '0;
          3:       return '1;
          default: return 32'd1;
        endcase
      end
      1:       return VEL_W'($urandom_range(0, 2097152)) - 32'd1048576;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, rare long stalls, and on request one very long
  // hold-off so that the output register fills and the input backs up.
  initial begin : sink
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != served) begin
        served = hold_asks;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(15, 60)) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // Watchdog: any beat on either stream counts as progress.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: T0 = 300 K, dt = 1, tau = 100. Before any start beat
    // the factor is one and the step is skipped, so velocities pass as-is.
    velocity(VEL_MAX, VEL_MIN, '0);
    start_step('0);                       // zero temperature: skipped
    velocity('1, 32'd1, 32'h1234_5678);
    start_step(TARGET_TEMP_RESET);        // T equals T0: lambda exactly one
    velocity(VEL_MAX, VEL_MIN, '1);
    start_step('1);                       // hottest temperature
    velocity(VEL_MAX, VEL_MIN, 32'h0001_0000);
    start_step(24'd1);                    // lambda of 4 or more saturates
    velocity(VEL_MAX, VEL_MIN, 32'h0001_8000);
    drain();

    // dt equal to tau makes lambda^2 = T0/T; T = 4*T0 gives lambda of one
    // half, where odd velocities land on rounding ties.
    load_config(TARGET_TEMP_RESET, 32'd1000, 32'd1000);
    start_step(24'd307200);
    velocity(32'd1, '1, 32'd3);
    velocity(VEL_MIN, VEL_MAX, 32'hFFFF_FFFD);
    drain();

    // Strong coupling: lambda^2 is zero at T = 2*T0, negative above it.
    load_config(24'd1000, 32'd2, 32'd1);
    start_step(24'd2000);
    velocity(32'h0002_0000, 32'hFFFE_0000, 32'd7);
    start_step('1);
    start_step(24'd500);                  // lambda^2 of three
    velocity(32'h0001_0000, 32'hFFFF_0000, VEL_MAX);
    drain();

    // Zero target temperature.
    load_config('0, 32'd1, 32'd100);
    start_step(TARGET_TEMP_RESET);
    velocity(32'h0003_0000, VEL_MIN, 32'd5);
    drain();

    // Zero coupling time behaves like a zero temperature.
    load_config('1, '1, '0);
    start_step(24'd1234);
    velocity(VEL_MAX, 32'h8000_0001, 32'd9);
    drain();

    // All registers at their maximum.
    load_config('1, '1, '1);
    start_step(24'd1);
    velocity(VEL_MAX, VEL_MIN, 32'hC000_0000);
    start_step('1);
    velocity(32'h7FFF_0000, 32'h0000_FFFF, 32'hFFFF_FFFE);
    drain();

    // Random phases. Mostly a start beat followed by a run of velocity
    // beats; sometimes the start beat is dropped so velocities reuse the
    // factor of an earlier step, and runs may hold back-to-back starts.
    for (int ph = 0; ph < PHASES; ph++) begin
      random_config();
      no_idle = (ph == 2 || ph == 5);
      // In one phase the receiver stops for a long stretch while the sender
      // keeps offering beats without gaps.
      if (ph == 2) hold_asks <= hold_asks + 1;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(0, 9) != 0) begin
          start_step(pick_temperature());
          sent++;
        end
        burst = $urandom_range(0, 12);
        repeat (burst) begin
          velocity(pick_velocity(), pick_velocity(), pick_velocity());
          sent++;
        end
      end
      drain();
      no_idle = 1'b0;
    end

    // Everything has been returned; keep the clock running before the verdict so
    // a stray extra result beat would still be caught.
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
